[rtl/sha_pkg.sv]
// sha-256 stream hasher package: constants, round table, state encoding
// no dependencies
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumH    = 8;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned CntW    = 61;
  localparam logic [7:0] PadByte  = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RND,
    ST_FIN,
    ST_PADZ,
    ST_OUT
  } sha_state_e;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] t [64];
    begin
      t = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return t[i];
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    begin
      return (x >> n) | (x << (32 - n));
    end
  endfunction

endpackage

[rtl/sha_if.sv]
// valid/ready stream interfaces for the hasher input and output beats
// depends on nothing
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha_ram.sv]
// generic single-port-write, one-read ram with registered read data
// no dependencies
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/sha256_stream_hasher_unit.sv]
// sha-256 stream hasher top level: block memory, round datapath, control
// depends on sha_pkg, sha_if, sha_ram
// a data beat is taken while idle; the 64th byte of a block starts the rounds
// a close beat runs padding and rounds for one or two blocks, then 8 output beats
// rounds run one per cycle off a 16-word shifting schedule; one beat in flight at a time
// reset restores the initial hash values and clears the byte counts; no clearing pass
module sha256_stream_hasher_unit (
  input logic clk_i,
  input logic rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  sha_state_e st_q, st_d;
  logic [31:0] h_q [NumH];
  logic [31:0] v_q [NumH];
  logic [31:0] w_q [BlkWords];
  logic [5:0]  fill_q;
  logic [CntW-1:0] cnt_q;
  logic [6:0]  rnd_q;
  logic        closing_q, lenblk_q;
  logic [2:0]  oidx_q;
  logic [5:0]  padpos_q;

  // block buffer as 16 big-endian words
  logic        bwe;
  logic [3:0]  bwaddr, braddr;
  logic [31:0] bwdata, brdata;

  sha_ram #(.Width(32), .Depth(BlkWords)) u_blk (
    .clk_i, .we_i(bwe), .waddr_i(bwaddr), .wdata_i(bwdata),
    .raddr_i(braddr), .rdata_o(brdata)
  );

  // partial word assembly in a register, written to memory when word completes
  logic [31:0] pw_q;
  logic [63:0] bits;
  assign bits = {cnt_q, 3'b000};

  logic acc;
  assign in_i.ready = (st_q == ST_IDLE);
  assign acc = in_i.valid && in_i.ready;

  // rnd_q==0 loads v, round r runs at rnd_q==r+1
  logic [6:0] r_eff;
  assign r_eff = rnd_q - 7'd1;

  // round datapath
  logic [31:0] wt, s0, s1, b1, b0, chv, majv, t1, t2;
  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wt = (rnd_q <= 7'd16) ? brdata : (w_q[0] + s0 + w_q[9] + s1);
    b1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    chv = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + b1 + chv + round_k(r_eff[5:0]) + wt;
    b0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    majv = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = b0 + majv;
  end

  // memory write mux
  always_comb begin
    bwe = 1'b0;
    bwaddr = fill_q[5:2];
    bwdata = {pw_q[23:0], in_i.data_byte};
    braddr = rnd_q[3:0];
    if (st_q == ST_IDLE && acc && !in_i.action) begin
      bwe = (fill_q[1:0] == 2'd3);
    end else if (st_q == ST_PADZ) begin
      bwe = 1'b1;
      bwaddr = padpos_q[5:2];
      if (lenblk_q && padpos_q[5:2] == 4'd14) bwdata = bits[63:32];
      else if (lenblk_q && padpos_q[5:2] == 4'd15) bwdata = bits[31:0];
      else bwdata = pw_q;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (acc) begin
        if (in_i.action) st_d = ST_PADZ;
        else if (fill_q == 6'd63) st_d = ST_RND;
      end
      ST_PADZ: if (padpos_q[5:2] == 4'd15) st_d = ST_RND;
      ST_RND: if (rnd_q == 7'(Rounds)) st_d = ST_FIN;
      ST_FIN: st_d = !closing_q ? ST_IDLE : (lenblk_q ? ST_OUT : ST_PADZ);
      ST_OUT: if (out_o.ready && oidx_q == 3'd7) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      fill_q <= '0;
      cnt_q <= '0;
      rnd_q <= '0;
      closing_q <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q <= '0;
      padpos_q <= '0;
      for (int i = 0; i < NumH; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_IDLE: if (acc) begin
          rnd_q <= '0;
          if (!in_i.action) begin
            fill_q <= fill_q + 6'd1;
            cnt_q <= cnt_q + 61'd1;
          end else begin
            closing_q <= 1'b1;
            padpos_q <= {fill_q[5:2], 2'b00};
            lenblk_q <= (fill_q < 6'd56);
          end
        end
        ST_PADZ: begin
          padpos_q <= padpos_q + 6'd4;
          rnd_q <= '0;
        end
        ST_RND: rnd_q <= rnd_q + 7'd1;
        ST_FIN: begin
          for (int i = 0; i < NumH; i++) h_q[i] <= h_q[i] + v_q[i];
          fill_q <= '0;
          padpos_q <= '0;
          lenblk_q <= 1'b1;
          oidx_q <= '0;
        end
        ST_OUT: if (out_o.ready) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < NumH; i++) h_q[i] <= init_hash(3'(i));
            cnt_q <= '0;
            closing_q <= 1'b0;
            lenblk_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: if (acc) begin
        if (!in_i.action) begin
          pw_q <= {pw_q[23:0], in_i.data_byte};
        end else begin
          // word with the pad byte, rest of the word zero
          unique case (fill_q[1:0])
            2'd0: pw_q <= {PadByte, 24'd0};
            2'd1: pw_q <= {pw_q[7:0], PadByte, 16'd0};
            2'd2: pw_q <= {pw_q[15:0], PadByte, 8'd0};
            default: pw_q <= {pw_q[23:0], PadByte};
          endcase
        end
      end
      ST_PADZ: pw_q <= '0;
      ST_RND: begin
        if (rnd_q == 7'd0) begin
          for (int i = 0; i < NumH; i++) v_q[i] <= h_q[i];
        end else begin
          v_q[0] <= t1 + t2;
          v_q[1] <= v_q[0];
          v_q[2] <= v_q[1];
          v_q[3] <= v_q[2];
          v_q[4] <= v_q[3] + t1;
          v_q[5] <= v_q[4];
          v_q[6] <= v_q[5];
          v_q[7] <= v_q[6];
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wt;
        end
      end
      ST_FIN: pw_q <= '0;
      default: ;
    endcase
  end

  assign out_o.valid = (st_q == ST_OUT);
  assign out_o.digest_word = h_q[oidx_q];
  assign out_o.word_index = oidx_q;
  assign out_o.last_word = (oidx_q == 3'd7);
endmodule

[rtl/sha_chk.sv]
// port-level checks for the sha-256 hasher
// depends on sha256_stream_hasher_unit ports
module sha_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i, in_ready_i, out_valid_i, out_ready_i,
  input logic [2:0] word_index_i,
  input logic last_word_i
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_word_i == (word_index_i == 3'd7))) else $error("last_word mismatch");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i)) else $error("input taken during output");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_word_i) |=>
      (out_valid_i && word_index_i == $past(word_index_i) + 3'd1))
    else $error("word order");
endmodule

bind sha256_stream_hasher_unit sha_chk u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .word_index_i(out_o.word_index), .last_word_i(out_o.last_word)
);
